### sv/shu_pkg.sv
package shu_pkg;

  localparam int VAL_W      = 16;
  localparam int WEIGHT_W   = 24;
  localparam int IDX_W      = 4;
  localparam int MODE_W     = 3;
  localparam int STATUS_W   = 2;
  localparam int SIZE_W     = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int SUM_SQ_W   = 64;
  localparam int SUM_W      = 48;
  localparam int MUL_A_W    = 32;
  localparam int PROD_W     = MUL_A_W + WEIGHT_W;

  localparam logic [MODE_W-1:0] MODE_SAMPLE  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_COMMIT  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PERTURB = 3'd2;
  localparam logic [MODE_W-1:0] MODE_READ    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RESTART = 3'd4;

  localparam logic [STATUS_W-1:0] ST_DONE       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SUCCESS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_SAT        = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_HISTORY_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_F       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_CR      = 2'd2;

  localparam logic [SIZE_W-1:0] RESET_SIZE = 5'd6;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_F_SQ,
    MUL_CR_SQ,
    MUL_F_W,
    MUL_CR_W,
    MUL_PROD_W
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_WFF,
    ACC_WF,
    ACC_WCC,
    ACC_WC
  } acc_sel_t;

  typedef struct packed {
    mul_sel_t mul;
    acc_sel_t acc;
    logic     count;
    logic     clear;
  } mac_cmd_t;

  typedef struct packed {
    logic             en;
    logic             term;
    logic [VAL_W-1:0] f;
    logic [VAL_W-1:0] cr;
  } hist_wr_t;

endpackage

### sv/shu_if.sv
interface shu_req_if;
  logic                          valid;
  logic                          ready;
  logic [shu_pkg::MODE_W-1:0]    mode;
  logic [shu_pkg::VAL_W-1:0]     f_value;
  logic [shu_pkg::VAL_W-1:0]     cr_value;
  logic [shu_pkg::WEIGHT_W-1:0]  weight;
  logic [shu_pkg::IDX_W-1:0]     slot_index;

  modport source(output valid, mode, f_value, cr_value, weight, slot_index, input ready);
  modport sink(input valid, mode, f_value, cr_value, weight, slot_index, output ready);
endinterface

interface shu_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [shu_pkg::STATUS_W-1:0]  status;
  logic [shu_pkg::IDX_W-1:0]     slot;
  logic [shu_pkg::VAL_W-1:0]     mem_f;
  logic [shu_pkg::VAL_W-1:0]     mem_cr;
  logic                          cr_is_terminal;

  modport source(output valid, status, slot, mem_f, mem_cr, cr_is_terminal, input ready);
  modport sink(input valid, status, slot, mem_f, mem_cr, cr_is_terminal, output ready);
endinterface

interface shu_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [shu_pkg::CFG_IDX_W-1:0]  index;
  logic [shu_pkg::CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### sv/shu_mac.sv
module shu_mac #(
  parameter int MAX_SUCCESS = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  shu_pkg::mac_cmd_t              cmd,
  input  logic [shu_pkg::VAL_W-1:0]      f,
  input  logic [shu_pkg::VAL_W-1:0]      cr,
  input  logic [shu_pkg::WEIGHT_W-1:0]   w,
  output logic [shu_pkg::SUM_SQ_W-1:0]   sum_wff,
  output logic [shu_pkg::SUM_W-1:0]      sum_wf,
  output logic [shu_pkg::SUM_SQ_W-1:0]   sum_wcc,
  output logic [shu_pkg::SUM_W-1:0]      sum_wc,
  output logic                           count_zero,
  output logic                           sat
);

  localparam int CNT_W  = $clog2(MAX_SUCCESS + 1);
  localparam int SQ_W   = shu_pkg::SUM_SQ_W;
  localparam int SW     = shu_pkg::SUM_W;
  localparam int ACC_W  = SQ_W + 1;
  localparam int A_W    = shu_pkg::MUL_A_W;
  localparam int B_W    = shu_pkg::WEIGHT_W;
  localparam int P_W    = shu_pkg::PROD_W;
  localparam logic [SQ_W-1:0] NARROW_MAX = {{(SQ_W - SW){1'b0}}, {SW{1'b1}}};

  logic [CNT_W-1:0] count;
  logic [P_W-1:0]   prod;
  logic [A_W-1:0]   mul_a;
  logic [B_W-1:0]   mul_b;
  logic [P_W-1:0]   product;
  logic [SQ_W-1:0]  acc_a;
  logic [ACC_W-1:0] acc_sum;
  logic             wide;
  logic             ovf;
  logic [SQ_W-1:0]  acc_res;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul)
      shu_pkg::MUL_F_SQ: begin
        mul_a = A_W'(f);
        mul_b = B_W'(f);
      end
      shu_pkg::MUL_CR_SQ: begin
        mul_a = A_W'(cr);
        mul_b = B_W'(cr);
      end
      shu_pkg::MUL_F_W: begin
        mul_a = A_W'(f);
        mul_b = w;
      end
      shu_pkg::MUL_CR_W: begin
        mul_a = A_W'(cr);
        mul_b = w;
      end
      shu_pkg::MUL_PROD_W: begin
        mul_a = prod[A_W-1:0];
        mul_b = w;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    product = P_W'(mul_a) * P_W'(mul_b);
  end

  always_comb begin
    acc_a = '0;
    wide  = 1'b0;
    case (cmd.acc)
      shu_pkg::ACC_WFF: begin
        acc_a = sum_wff;
        wide  = 1'b1;
      end
      shu_pkg::ACC_WF:  acc_a = SQ_W'(sum_wf);
      shu_pkg::ACC_WCC: begin
        acc_a = sum_wcc;
        wide  = 1'b1;
      end
      shu_pkg::ACC_WC:  acc_a = SQ_W'(sum_wc);
      default:          acc_a = '0;
    endcase
    acc_sum = {1'b0, acc_a} + ACC_W'(prod);
    ovf     = wide ? acc_sum[SQ_W] : (|acc_sum[SQ_W:SW]);
    if (ovf) begin
      acc_res = wide ? {SQ_W{1'b1}} : NARROW_MAX;
    end else begin
      acc_res = acc_sum[SQ_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul != shu_pkg::MUL_NONE) begin
      prod <= product;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_wff <= '0;
      sum_wf  <= '0;
      sum_wcc <= '0;
      sum_wc  <= '0;
      count   <= '0;
      sat     <= 1'b0;
    end else if (cmd.clear) begin
      sum_wff <= '0;
      sum_wf  <= '0;
      sum_wcc <= '0;
      sum_wc  <= '0;
      count   <= '0;
    end else begin
      if (cmd.count) begin
        if (count >= CNT_W'(MAX_SUCCESS)) begin
          sat <= 1'b1;
        end else begin
          count <= count + CNT_W'(1);
          sat   <= 1'b0;
        end
      end
      case (cmd.acc)
        shu_pkg::ACC_WFF: sum_wff <= acc_res;
        shu_pkg::ACC_WF:  sum_wf  <= acc_res[SW-1:0];
        shu_pkg::ACC_WCC: sum_wcc <= acc_res;
        shu_pkg::ACC_WC:  sum_wc  <= acc_res[SW-1:0];
        default: ;
      endcase
      if (cmd.acc != shu_pkg::ACC_NONE && ovf) begin
        sat <= 1'b1;
      end
    end
  end

  assign count_zero = (count == '0);

endmodule

### sv/shu_div.sv
module shu_div #(
  parameter int FRAC_BITS = 15
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [shu_pkg::SUM_SQ_W-1:0] num,
  input  logic [shu_pkg::SUM_W-1:0]    den,
  output logic                         done,
  output logic [shu_pkg::VAL_W-1:0]    mean
);

  localparam int QW = shu_pkg::SUM_SQ_W;
  localparam int RW = shu_pkg::SUM_W;
  localparam int VW = shu_pkg::VAL_W;
  localparam int CW = $clog2(QW);
  localparam logic [VW-1:0] ONE = VW'(2 ** FRAC_BITS);

  logic          running;
  logic          rounding;
  logic [CW-1:0] cnt;
  logic [QW-1:0] quo;
  logic [RW-1:0] rem;
  logic [RW-1:0] den_r;
  logic [RW:0]   trial;
  logic          fits;
  logic          up;
  logic [QW:0]   q_round;

  always_comb begin
    trial   = {rem, quo[QW-1]};
    fits    = trial >= {1'b0, den_r};
    up      = {rem, 1'b0} >= {1'b0, den_r};
    q_round = {1'b0, quo} + (QW + 1)'(up);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running  <= 1'b0;
      rounding <= 1'b0;
      done     <= 1'b0;
      cnt      <= '0;
    end else begin
      done <= rounding && !start && !running;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(QW - 1)) begin
          running  <= 1'b0;
          rounding <= 1'b1;
        end
      end else if (rounding) begin
        rounding <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= num;
      rem   <= '0;
      den_r <= den;
    end else if (running) begin
      if (fits) begin
        rem <= RW'(trial - {1'b0, den_r});
      end else begin
        rem <= trial[RW-1:0];
      end
      quo <= {quo[QW-2:0], fits};
    end else if (rounding) begin
      mean <= (q_round > (QW + 1)'(ONE)) ? ONE : q_round[VW-1:0];
    end
  end

endmodule

### sv/shu_hist.sv
module shu_hist #(
  parameter int DEPTH     = 16,
  parameter int FRAC_BITS = 15,
  parameter int AW        = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  shu_pkg::hist_wr_t         wr,
  input  logic [AW-1:0]             waddr,
  input  logic                      restart,
  input  logic [shu_pkg::VAL_W-1:0] fill_f_in,
  input  logic [shu_pkg::VAL_W-1:0] fill_cr_in,
  input  logic                      rd_en,
  input  logic [AW-1:0]             raddr,
  output logic [shu_pkg::VAL_W-1:0] rd_f,
  output logic [shu_pkg::VAL_W-1:0] rd_cr,
  output logic                      rd_term,
  output logic                      chk_term
);

  localparam int VW = shu_pkg::VAL_W;
  localparam logic [VW-1:0] HALF = VW'(2 ** (FRAC_BITS - 1));

  logic [2*VW-1:0]  mem [DEPTH];
  logic [2*VW-1:0]  rd_word;
  logic [DEPTH-1:0] valid;
  logic [DEPTH-1:0] term;
  logic [VW-1:0]    fill_f;
  logic [VW-1:0]    fill_cr;
  logic             rd_valid;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[waddr] <= {wr.f, wr.cr};
    end
    if (rd_en) begin
      rd_word  <= mem[raddr];
      rd_valid <= valid[raddr];
      rd_term  <= term[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      term    <= '0;
      fill_f  <= HALF;
      fill_cr <= HALF;
    end else if (restart) begin
      valid   <= '0;
      term    <= '0;
      fill_f  <= fill_f_in;
      fill_cr <= fill_cr_in;
    end else if (wr.en) begin
      valid[waddr] <= 1'b1;
      term[waddr]  <= wr.term;
    end
  end

  assign rd_f     = rd_valid ? rd_word[2*VW-1:VW] : fill_f;
  assign rd_cr    = rd_term ? '0 : (rd_valid ? rd_word[VW-1:0] : fill_cr);
  assign chk_term = term[waddr];

endmodule

### sv/shade_history_memory_update.sv
// Success-history memory for an adaptive differential-evolution controller: a circular
// history of F and CR values in fixed point with a terminal flag per slot, weighted
// success sums and Lehmer-mean commits. One transaction at a time: ready drops after an
// accept and returns once the result is in the output register. A success sample passes
// through the accept, 7 steps through the shared multiplier and saturating accumulator,
// then a history read and the response. A commit with successes makes up to two passes
// through the shared radix-2 divider, each a start, 64 quotient bits, rounding and a
// handoff. Perturb and restart go through a write or restart state before the history
// read and the response, read and unused modes go straight to the history read, and a
// read beyond the size skips it. A result not yet taken holds the next one in the
// response state. Restart clears per-slot valid bits at once, so there is no fill sweep.
module shade_history_memory_update #(
  parameter int HISTORY_DEPTH = 16,
  parameter int MAX_SUCCESS   = 256,
  parameter int FRAC_BITS     = 15,
  parameter int WEIGHT_BITS   = 24
) (
  input logic       clk,
  input logic       rst,
  shu_req_if.sink   req,
  shu_rsp_if.source rsp,
  shu_cfg_if.sink   cfg
);

  localparam int AW  = $clog2(HISTORY_DEPTH);
  localparam int SW  = $clog2(HISTORY_DEPTH + 32);
  localparam int VW  = shu_pkg::VAL_W;
  localparam int WW  = shu_pkg::WEIGHT_W;
  localparam int IW  = shu_pkg::IDX_W;
  localparam int ZW  = shu_pkg::SIZE_W;
  localparam logic [VW-1:0] ONE = VW'(2 ** FRAC_BITS);

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_MAC     = 10'b0000000010,
    S_DSF     = 10'b0000000100,
    S_DWF     = 10'b0000001000,
    S_DSC     = 10'b0000010000,
    S_DWC     = 10'b0000100000,
    S_WR      = 10'b0001000000,
    S_RESTART = 10'b0010000000,
    S_RD      = 10'b0100000000,
    S_RSP     = 10'b1000000000
  } state_t;

  typedef enum logic [6:0] {
    M_SQ_F  = 7'b0000001,
    M_W_FF  = 7'b0000010,
    M_W_F   = 7'b0000100,
    M_SQ_CR = 7'b0001000,
    M_W_CC  = 7'b0010000,
    M_W_C   = 7'b0100000,
    M_ACC_C = 7'b1000000
  } mac_step_t;

  function automatic logic [VW-1:0] clamp_one(input logic [VW-1:0] v);
    return (v > ONE) ? ONE : v;
  endfunction

  state_t    state;
  mac_step_t step;
  mac_step_t step_next;

  logic [ZW-1:0] history_size;
  logic [VW-1:0] init_f;
  logic [VW-1:0] init_cr;
  logic [AW-1:0] ptr;

  logic [shu_pkg::MODE_W-1:0]   it_mode;
  logic [VW-1:0]                it_f;
  logic [VW-1:0]                it_cr;
  logic [WW-1:0]                it_w;
  logic [IW-1:0]                it_idx;
  logic [shu_pkg::STATUS_W-1:0] st;
  logic                         range_err;
  logic [AW-1:0]                addr;
  logic [VW-1:0]                new_f;
  logic [VW-1:0]                new_cr;
  logic                         new_term;

  logic [SW-1:0] size_ext;
  logic [SW-1:0] eff_size;
  logic [SW-1:0] ptr_inc;
  logic [AW-1:0] ptr_adv;
  logic          req_acc;

  logic                         req_range;
  logic [shu_pkg::STATUS_W-1:0] req_st;
  logic [AW-1:0]                req_addr;

  shu_pkg::mac_cmd_t           mac_cmd;
  logic [shu_pkg::SUM_SQ_W-1:0] sum_wff;
  logic [shu_pkg::SUM_W-1:0]    sum_wf;
  logic [shu_pkg::SUM_SQ_W-1:0] sum_wcc;
  logic [shu_pkg::SUM_W-1:0]    sum_wc;
  logic                         count_zero;
  logic                         sat;

  logic                         div_start;
  logic [shu_pkg::SUM_SQ_W-1:0] div_num;
  logic [shu_pkg::SUM_W-1:0]    div_den;
  logic                         div_done;
  logic [VW-1:0]                div_mean;

  shu_pkg::hist_wr_t hist_wr;
  logic              hist_restart;
  logic              rd_en;
  logic [VW-1:0]     rd_f;
  logic [VW-1:0]     rd_cr;
  logic              rd_term;
  logic              chk_term;

  logic rsp_valid;
  logic rsp_load;

  always_comb begin
    size_ext = SW'(history_size);
    if (history_size == '0) begin
      eff_size = SW'(1);
    end else if (size_ext > SW'(HISTORY_DEPTH)) begin
      eff_size = SW'(HISTORY_DEPTH);
    end else begin
      eff_size = size_ext;
    end
    ptr_inc = SW'(ptr) + SW'(1);
    ptr_adv = (ptr_inc >= eff_size) ? '0 : AW'(ptr_inc);
  end

  assign req.ready = (state == S_IDLE);
  assign req_acc   = req.valid && req.ready;
  assign cfg.ready = 1'b1;

  always_comb begin
    req_range = (SW'(req.slot_index) >= eff_size);
    req_st    = shu_pkg::ST_DONE;
    req_addr  = ptr;
    case (req.mode)
      shu_pkg::MODE_COMMIT: begin
        if (count_zero) begin
          req_st = shu_pkg::ST_NO_SUCCESS;
        end
      end
      shu_pkg::MODE_READ: begin
        if (req_range) begin
          req_st = shu_pkg::ST_RANGE;
        end else begin
          req_addr = AW'(req.slot_index);
        end
      end
      shu_pkg::MODE_RESTART: req_addr = '0;
      default: ;
    endcase
  end

  always_comb begin
    mac_cmd.mul   = shu_pkg::MUL_NONE;
    mac_cmd.acc   = shu_pkg::ACC_NONE;
    mac_cmd.count = 1'b0;
    mac_cmd.clear = (state == S_WR) && (it_mode == shu_pkg::MODE_COMMIT);
    step_next     = step;
    if (state == S_MAC) begin
      case (step)
        M_SQ_F: begin
          mac_cmd.count = 1'b1;
          mac_cmd.mul   = shu_pkg::MUL_F_SQ;
          step_next     = M_W_FF;
        end
        M_W_FF: begin
          mac_cmd.mul = shu_pkg::MUL_PROD_W;
          step_next   = M_W_F;
        end
        M_W_F: begin
          mac_cmd.mul = shu_pkg::MUL_F_W;
          mac_cmd.acc = shu_pkg::ACC_WFF;
          step_next   = M_SQ_CR;
        end
        M_SQ_CR: begin
          mac_cmd.mul = shu_pkg::MUL_CR_SQ;
          mac_cmd.acc = shu_pkg::ACC_WF;
          step_next   = M_W_CC;
        end
        M_W_CC: begin
          mac_cmd.mul = shu_pkg::MUL_PROD_W;
          step_next   = M_W_C;
        end
        M_W_C: begin
          mac_cmd.mul = shu_pkg::MUL_CR_W;
          mac_cmd.acc = shu_pkg::ACC_WCC;
          step_next   = M_ACC_C;
        end
        M_ACC_C: begin
          mac_cmd.acc = shu_pkg::ACC_WC;
          step_next   = M_SQ_F;
        end
        default: step_next = M_SQ_F;
      endcase
    end
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = sum_wff;
    div_den   = sum_wf;
    if (state == S_DSF) begin
      div_start = (sum_wf != '0);
    end else if (state == S_DSC) begin
      div_num   = sum_wcc;
      div_den   = sum_wc;
      div_start = (sum_wc != '0) && !chk_term;
    end
  end

  always_comb begin
    hist_wr.en   = (state == S_WR);
    hist_wr.term = new_term;
    hist_wr.f    = new_f;
    hist_wr.cr   = new_term ? '0 : new_cr;
    hist_restart = (state == S_RESTART);
    rd_en        = (state == S_RD);
    rsp_load     = (state == S_RSP) && (!rsp_valid || rsp.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      step         <= M_SQ_F;
      ptr          <= '0;
      history_size <= shu_pkg::RESET_SIZE;
      init_f       <= VW'(2 ** (FRAC_BITS - 1));
      init_cr      <= VW'(2 ** (FRAC_BITS - 1));
      rsp_valid    <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          shu_pkg::REG_HISTORY_SIZE: history_size <= cfg.data[ZW-1:0];
          shu_pkg::REG_INIT_F:       init_f       <= cfg.data[VW-1:0];
          shu_pkg::REG_INIT_CR:      init_cr      <= cfg.data[VW-1:0];
          default: ;
        endcase
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      step <= step_next;
      case (state)
        S_IDLE: begin
          if (req_acc) begin
            case (req.mode)
              shu_pkg::MODE_SAMPLE:  state <= S_MAC;
              shu_pkg::MODE_COMMIT:  state <= count_zero ? S_RD : S_DSF;
              shu_pkg::MODE_PERTURB: state <= S_WR;
              shu_pkg::MODE_READ:    state <= req_range ? S_RSP : S_RD;
              shu_pkg::MODE_RESTART: state <= S_RESTART;
              default:               state <= S_RD;
            endcase
          end
        end
        S_MAC: begin
          if (step == M_ACC_C) begin
            state <= S_RD;
          end
        end
        S_DSF:  state <= div_start ? S_DWF : S_DSC;
        S_DWF: begin
          if (div_done) begin
            state <= S_DSC;
          end
        end
        S_DSC:  state <= div_start ? S_DWC : S_WR;
        S_DWC: begin
          if (div_done) begin
            state <= S_WR;
          end
        end
        S_WR: begin
          ptr   <= ptr_adv;
          state <= S_RD;
        end
        S_RESTART: begin
          ptr   <= '0;
          state <= S_RD;
        end
        S_RD: state <= S_RSP;
        S_RSP: begin
          if (rsp_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (req_acc) begin
          it_mode   <= req.mode;
          it_f      <= clamp_one(req.f_value);
          it_cr     <= clamp_one(req.cr_value);
          it_w      <= WW'(req.weight[WEIGHT_BITS-1:0]);
          it_idx    <= req.slot_index;
          addr      <= req_addr;
          st        <= req_st;
          range_err <= (req.mode == shu_pkg::MODE_READ) && req_range;
          new_f     <= clamp_one(req.f_value);
          new_cr    <= clamp_one(req.cr_value);
          new_term  <= 1'b0;
        end
      end
      S_DSF: begin
        if (!div_start) begin
          new_f <= '0;
        end
      end
      S_DWF: begin
        if (div_done) begin
          new_f <= div_mean;
        end
      end
      S_DSC: new_term <= !div_start;
      S_DWC: begin
        if (div_done) begin
          new_cr <= div_mean;
        end
      end
      S_RD: begin
        if (it_mode == shu_pkg::MODE_SAMPLE && sat) begin
          st <= shu_pkg::ST_SAT;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.status         <= st;
      rsp.slot           <= range_err ? it_idx : IW'(addr);
      rsp.mem_f          <= range_err ? '0 : rd_f;
      rsp.mem_cr         <= range_err ? '0 : rd_cr;
      rsp.cr_is_terminal <= range_err ? 1'b0 : rd_term;
    end
  end

  assign rsp.valid = rsp_valid;

  shu_mac #(
    .MAX_SUCCESS(MAX_SUCCESS)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .cmd       (mac_cmd),
    .f         (it_f),
    .cr        (it_cr),
    .w         (it_w),
    .sum_wff   (sum_wff),
    .sum_wf    (sum_wf),
    .sum_wcc   (sum_wcc),
    .sum_wc    (sum_wc),
    .count_zero(count_zero),
    .sat       (sat)
  );

  shu_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .mean (div_mean)
  );

  shu_hist #(
    .DEPTH    (HISTORY_DEPTH),
    .FRAC_BITS(FRAC_BITS),
    .AW       (AW)
  ) u_hist (
    .clk       (clk),
    .rst       (rst),
    .wr        (hist_wr),
    .waddr     (addr),
    .restart   (hist_restart),
    .fill_f_in (clamp_one(init_f)),
    .fill_cr_in(clamp_one(init_cr)),
    .rd_en     (rd_en),
    .raddr     (addr),
    .rd_f      (rd_f),
    .rd_cr     (rd_cr),
    .rd_term   (rd_term),
    .chk_term  (chk_term)
  );

endmodule

### sv/shu_checker.sv
module shu_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [shu_pkg::STATUS_W-1:0] status,
  input logic [shu_pkg::IDX_W-1:0]    slot,
  input logic [shu_pkg::VAL_W-1:0]    mem_f,
  input logic [shu_pkg::VAL_W-1:0]    mem_cr,
  input logic                         cr_is_terminal
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid
      && $stable({status, slot, mem_f, mem_cr, cr_is_terminal}))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("ready stayed high after an accepted transaction");

  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == shu_pkg::ST_RANGE |->
      mem_f == '0 && mem_cr == '0 && !cr_is_terminal)
    else $error("out-of-range read returned entry data");

  a_terminal_cr: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && cr_is_terminal |-> mem_cr == '0)
    else $error("terminal entry with nonzero CR");

endmodule

bind shade_history_memory_update shu_checker u_shu_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .status        (rsp.status),
  .slot          (rsp.slot),
  .mem_f         (rsp.mem_f),
  .mem_cr        (rsp.mem_cr),
  .cr_is_terminal(rsp.cr_is_terminal)
);

### test/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HIST_DEPTH     = 16;
  localparam int SUCCESS_LIMIT  = 256;
  localparam int FRAC           = 15;
  localparam int LIMIT_CYCLES   = 1500000;
  localparam int HOLD_LEN       = 400;
  localparam int TAIL_CYCLES    = 160;
  localparam int PHASE_ITEMS    = 45;
  localparam int SAT_SAMPLES    = 1040;

  localparam int VW  = shu_pkg::VAL_W;
  localparam int WW  = shu_pkg::WEIGHT_W;
  localparam int IW  = shu_pkg::IDX_W;
  localparam int MW  = shu_pkg::MODE_W;
  localparam int TW  = shu_pkg::STATUS_W;
  localparam int ZW  = shu_pkg::SIZE_W;
  localparam int CIW = shu_pkg::CFG_IDX_W;
  localparam int CDW = shu_pkg::CFG_DATA_W;

  localparam logic [VW-1:0]    Q15_ONE    = VW'(1 << FRAC);
  localparam logic [VW-1:0]    Q15_HALF   = VW'(1 << (FRAC - 1));
  localparam logic [WW-1:0]    WEIGHT_MAX = '1;
  localparam logic [63:0]      SUM48_MAX  = 64'h0000_FFFF_FFFF_FFFF;
  localparam logic [63:0]      SUM64_MAX  = '1;

  localparam logic [CIW-1:0] REG_SPARE        = 2'd3;
  localparam logic [MW-1:0]  MODE_SPARE_FIRST = 3'd5;
  localparam logic [MW-1:0]  MODE_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic [MW-1:0] mode;
    logic [VW-1:0] f_value;
    logic [VW-1:0] cr_value;
    logic [WW-1:0] weight;
    logic [IW-1:0] slot_index;
  } hist_req_t;

  typedef struct packed {
    logic [TW-1:0] status;
    logic [IW-1:0] slot;
    logic [VW-1:0] mem_f;
    logic [VW-1:0] mem_cr;
    logic          cr_is_terminal;
  } slot_report_t;

  logic clk = 1'b0;
  logic rst;

  shu_req_if req();
  shu_rsp_if rsp();
  shu_cfg_if cfg();

  shade_history_memory_update uut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp),
    .cfg(cfg)
  );

  always #4 clk = ~clk;

  // history model
  logic [VW-1:0]  hist_f [HIST_DEPTH];
  logic [VW-1:0]  hist_cr [HIST_DEPTH];
  bit             hist_term [HIST_DEPTH];
  logic [IW-1:0]  hist_ptr;
  logic [63:0]    sum_wff;
  logic [47:0]    sum_wf;
  logic [63:0]    sum_wcc;
  logic [47:0]    sum_wc;
  int unsigned    success_n;
  logic [ZW-1:0]  reg_size;
  logic [VW-1:0]  reg_init_f;
  logic [VW-1:0]  reg_init_cr;

  slot_report_t pending_reports[$];
  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count = 0;
  int unsigned  gap_pct = 0;
  int unsigned  stall_pct = 0;
  bit           long_hold = 1'b0;

  function automatic void reset_history_model();
    for (int i = 0; i < HIST_DEPTH; i++) begin
      hist_f[i] = Q15_HALF;
      hist_cr[i] = Q15_HALF;
      hist_term[i] = 1'b0;
    end
    hist_ptr = '0;
    sum_wff = '0;
    sum_wf = '0;
    sum_wcc = '0;
    sum_wc = '0;
    success_n = 0;
    reg_size = shu_pkg::RESET_SIZE;
    reg_init_f = Q15_HALF;
    reg_init_cr = Q15_HALF;
  endfunction

  function automatic void enqueue_report(slot_report_t r);
    pending_reports.insert(pending_reports.size(), r);
  endfunction

  function automatic logic [VW-1:0] clamp_q15(logic [63:0] v);
    return (v > 64'(Q15_ONE)) ? Q15_ONE : VW'(v);
  endfunction

  function automatic int unsigned active_slots();
    if (reg_size == 0) return 1;
    if (reg_size > HIST_DEPTH) return HIST_DEPTH;
    return reg_size;
  endfunction

  // top bit flags a clipped sum
  function automatic logic [64:0] add_clip(logic [63:0] a, logic [63:0] b, logic [63:0] lim);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s > {1'b0, lim}) return {1'b1, lim};
    return s;
  endfunction

  function automatic logic [VW-1:0] lehmer_mean(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    q = num / den;
    r = num % den;
    if (r >= den - r) q = q + 1;
    return clamp_q15(q);
  endfunction

  function automatic slot_report_t slot_view(logic [TW-1:0] st, int unsigned s);
    slot_report_t r;
    r.status = st;
    r.slot = IW'(s);
    r.mem_f = hist_f[s];
    r.mem_cr = hist_term[s] ? '0 : hist_cr[s];
    r.cr_is_terminal = hist_term[s];
    return r;
  endfunction

  function automatic void advance_ptr();
    int unsigned n;
    n = hist_ptr + 1;
    hist_ptr = (n >= active_slots()) ? '0 : IW'(n);
  endfunction

  function automatic slot_report_t update_history_model(hist_req_t it);
    logic [VW-1:0] f;
    logic [VW-1:0] cr;
    logic [63:0]   w;
    logic [63:0]   wf;
    logic [63:0]   wc;
    logic [64:0]   s;
    bit            clipped;
    int unsigned   p;
    slot_report_t  r;
    f = clamp_q15(64'(it.f_value));
    cr = clamp_q15(64'(it.cr_value));
    w = 64'(it.weight);
    p = hist_ptr;
    case (it.mode)
      shu_pkg::MODE_SAMPLE: begin
        clipped = 1'b0;
        if (success_n >= SUCCESS_LIMIT) clipped = 1'b1;
        else success_n++;
        wf = w * 64'(f);
        wc = w * 64'(cr);
        s = add_clip(sum_wff, wf * 64'(f), SUM64_MAX);
        clipped |= s[64];
        sum_wff = s[63:0];
        s = add_clip(64'(sum_wf), wf, SUM48_MAX);
        clipped |= s[64];
        sum_wf = s[47:0];
        s = add_clip(sum_wcc, wc * 64'(cr), SUM64_MAX);
        clipped |= s[64];
        sum_wcc = s[63:0];
        s = add_clip(64'(sum_wc), wc, SUM48_MAX);
        clipped |= s[64];
        sum_wc = s[47:0];
        r = slot_view(clipped ? shu_pkg::ST_SAT : shu_pkg::ST_DONE, p);
      end
      shu_pkg::MODE_COMMIT: begin
        if (success_n == 0) begin
          r = slot_view(shu_pkg::ST_NO_SUCCESS, p);
        end else begin
          hist_f[p] = (sum_wf == 0) ? '0 : lehmer_mean(sum_wff, 64'(sum_wf));
          if (sum_wc == 0 || hist_term[p]) begin
            hist_term[p] = 1'b1;
            hist_cr[p] = '0;
          end else begin
            hist_cr[p] = lehmer_mean(sum_wcc, 64'(sum_wc));
          end
          sum_wff = '0;
          sum_wf = '0;
          sum_wcc = '0;
          sum_wc = '0;
          success_n = 0;
          advance_ptr();
          r = slot_view(shu_pkg::ST_DONE, p);
        end
      end
      shu_pkg::MODE_PERTURB: begin
        hist_f[p] = f;
        hist_cr[p] = cr;
        hist_term[p] = 1'b0;
        advance_ptr();
        r = slot_view(shu_pkg::ST_DONE, p);
      end
      shu_pkg::MODE_READ: begin
        if (it.slot_index >= active_slots()) begin
          r = '0;
          r.status = shu_pkg::ST_RANGE;
          r.slot = it.slot_index;
        end else begin
          r = slot_view(shu_pkg::ST_DONE, it.slot_index);
        end
      end
      shu_pkg::MODE_RESTART: begin
        for (int i = 0; i < HIST_DEPTH; i++) begin
          hist_f[i] = clamp_q15(64'(reg_init_f));
          hist_cr[i] = clamp_q15(64'(reg_init_cr));
          hist_term[i] = 1'b0;
        end
        hist_ptr = '0;
        r = slot_view(shu_pkg::ST_DONE, 0);
      end
      default: r = slot_view(shu_pkg::ST_DONE, p);
    endcase
    return r;
  endfunction

  function automatic hist_req_t make_req(logic [MW-1:0] m, logic [VW-1:0] f,
                                         logic [VW-1:0] c, logic [WW-1:0] w,
                                         logic [IW-1:0] idx);
    hist_req_t it;
    it.mode = m;
    it.f_value = f;
    it.cr_value = c;
    it.weight = w;
    it.slot_index = idx;
    return it;
  endfunction

  function automatic logic [VW-1:0] rand_q15();
    case ($urandom_range(15))
      0: return '0;
      1: return Q15_ONE;
      2: return '1;
      3: return VW'($urandom_range(65535, 32769));
      default: return VW'($urandom_range(32768));
    endcase
  endfunction

  function automatic logic [WW-1:0] rand_weight();
    case ($urandom_range(7))
      0: return '0;
      1: return WEIGHT_MAX;
      2: return WW'($urandom_range(255));
      default: return WW'($urandom);
    endcase
  endfunction

  function automatic hist_req_t rand_req(logic [MW-1:0] m);
    return make_req(m, rand_q15(), rand_q15(), rand_weight(), IW'($urandom_range(15)));
  endfunction

  task automatic send_req(input hist_req_t it);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < gap_pct) gap++;
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.mode <= it.mode;
    req.f_value <= it.f_value;
    req.cr_value <= it.cr_value;
    req.weight <= it.weight;
    req.slot_index <= it.slot_index;
    do @(posedge clk); while (!req.ready);
    enqueue_report(update_history_model(it));
  endtask

  task automatic drain_reports();
    req.valid <= 1'b0;
    #1;
    while (pending_reports.size() != 0) begin
      @(posedge clk);
      #1;
    end
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CIW-1:0] idx, input logic [CDW-1:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      shu_pkg::REG_HISTORY_SIZE: reg_size = val[ZW-1:0];
      shu_pkg::REG_INIT_F:       reg_init_f = val;
      shu_pkg::REG_INIT_CR:      reg_init_cr = val;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [CDW-1:0] size, input logic [VW-1:0] f0,
                           input logic [VW-1:0] cr0);
    drain_reports();
    write_reg(shu_pkg::REG_HISTORY_SIZE, size);
    write_reg(shu_pkg::REG_INIT_F, f0);
    write_reg(shu_pkg::REG_INIT_CR, cr0);
    cfg.valid <= 1'b0;
  endtask

  task automatic test_reset_contents();
    send_req(make_req(shu_pkg::MODE_READ, 0, 0, 0, 0));
    send_req(make_req(shu_pkg::MODE_READ, 0, 0, 0, 5));
    send_req(make_req(shu_pkg::MODE_READ, 0, 0, 0, 6));
    send_req(make_req(shu_pkg::MODE_READ, 0, 0, 0, 15));
  endtask

  task automatic test_directed_modes();
    send_req(make_req(shu_pkg::MODE_SAMPLE, '1, Q15_ONE, WEIGHT_MAX, 0));
    send_req(make_req(shu_pkg::MODE_SAMPLE, 0, 0, 0, '1));
    send_req(make_req(shu_pkg::MODE_COMMIT, 0, 0, 0, 0));
    send_req(make_req(shu_pkg::MODE_COMMIT, 0, 0, 0, 0));
    // mean of 1 and 3 lands exactly on a half
    send_req(make_req(shu_pkg::MODE_SAMPLE, 1, 1, 1, 0));
    send_req(make_req(shu_pkg::MODE_SAMPLE, 3, 3, 1, 0));
    send_req(make_req(shu_pkg::MODE_COMMIT, 0, 0, 0, 0));
    send_req(make_req(shu_pkg::MODE_SAMPLE, 1234, 0, 5, 0));
    send_req(make_req(shu_pkg::MODE_COMMIT, 0, 0, 0, 0));
    send_req(make_req(shu_pkg::MODE_SAMPLE, 0, 1000, 7, 0));
    send_req(make_req(shu_pkg::MODE_COMMIT, 0, 0, 0, 0));
    send_req(make_req(shu_pkg::MODE_READ, 0, 0, 0, 2));
    send_req(make_req(shu_pkg::MODE_PERTURB, Q15_ONE, '1, WEIGHT_MAX, 0));
    send_req(make_req(shu_pkg::MODE_READ, 0, 0, 0, 15));
    send_req(make_req(shu_pkg::MODE_READ, 0, 0, 0, 6));
    for (int m = MODE_SPARE_FIRST; m <= MODE_SPARE_LAST; m++)
      send_req(make_req(MW'(m), '1, '1, WEIGHT_MAX, '1));
    send_req(make_req(shu_pkg::MODE_RESTART, 0, 0, 0, 0));
    send_req(make_req(shu_pkg::MODE_READ, 0, 0, 0, 2));
  endtask

  task automatic test_terminal_slot();
    configure(0, Q15_ONE, '1);
    send_req(make_req(shu_pkg::MODE_SAMPLE, 100, 0, 9, 0));
    send_req(make_req(shu_pkg::MODE_COMMIT, 0, 0, 0, 0));
    send_req(make_req(shu_pkg::MODE_SAMPLE, 700, 500, 3, 0));
    send_req(make_req(shu_pkg::MODE_COMMIT, 0, 0, 0, 0));
    send_req(make_req(shu_pkg::MODE_READ, 0, 0, 0, 0));
    send_req(make_req(shu_pkg::MODE_READ, 0, 0, 0, 1));
    send_req(make_req(shu_pkg::MODE_PERTURB, 200, 300, 0, 0));
    send_req(make_req(shu_pkg::MODE_READ, 0, 0, 0, 0));
    send_req(make_req(shu_pkg::MODE_RESTART, 0, 0, 0, 0));
  endtask

  task automatic test_saturation();
    configure(16, 0, 0);
    repeat (SAT_SAMPLES)
      send_req(make_req(shu_pkg::MODE_SAMPLE, '1, Q15_ONE, WEIGHT_MAX, 0));
    send_req(make_req(shu_pkg::MODE_COMMIT, 0, 0, 0, 0));
    send_req(make_req(shu_pkg::MODE_READ, 0, 0, 0, 0));
  endtask

  task automatic test_backpressure();
    gap_pct = 0;
    stall_pct <= 0;
    long_hold <= 1'b1;
    repeat (30) send_req(rand_req(MW'($urandom_range(3))));
    drain_reports();
    long_hold <= 1'b0;
  endtask

  task automatic test_random_traffic(input int unsigned gap, input int unsigned stall);
    int unsigned pick;
    logic [MW-1:0] m;
    gap_pct = gap;
    stall_pct <= stall;
    for (int k = 0; k < PHASE_ITEMS; k++) begin
      pick = $urandom_range(99);
      if (pick < 60) m = shu_pkg::MODE_SAMPLE;
      else if (pick < 74) m = shu_pkg::MODE_COMMIT;
      else if (pick < 82) m = shu_pkg::MODE_PERTURB;
      else if (pick < 93) m = shu_pkg::MODE_READ;
      else if (pick < 96) m = shu_pkg::MODE_RESTART;
      else m = MW'($urandom_range(MODE_SPARE_LAST, MODE_SPARE_FIRST));
      send_req(rand_req(m));
    end
  endtask

  initial begin : rsp_pacing
    int unsigned held;
    held = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold && held < HOLD_LEN) begin
        rsp.ready <= 1'b0;
        held++;
      end else begin
        if (!long_hold) held = 0;
        rsp.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    slot_report_t got;
    slot_report_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      got.status = rsp.status;
      got.slot = rsp.slot;
      got.mem_f = rsp.mem_f;
      got.mem_cr = rsp.mem_cr;
      got.cr_is_terminal = rsp.cr_is_terminal;
      if (pending_reports.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected transaction: status %0d slot %0d f %0d cr %0d term %0d",
                   got.status, got.slot, got.mem_f, got.mem_cr, got.cr_is_terminal);
      end else begin
        want = pending_reports.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: expected status %0d slot %0d f %0d cr %0d term %0d",
                     want.status, want.slot, want.mem_f, want.mem_cr, want.cr_is_terminal);
            $display("          got      status %0d slot %0d f %0d cr %0d term %0d",
                     got.status, got.slot, got.mem_f, got.mem_cr, got.cr_is_terminal);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    req.valid <= 1'b0;
    req.mode <= '0;
    req.f_value <= '0;
    req.cr_value <= '0;
    req.weight <= '0;
    req.slot_index <= '0;
    cfg.valid <= 1'b0;
    cfg.index <= '0;
    cfg.data <= '0;
    reset_history_model();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_reset_contents();
    test_directed_modes();
    test_terminal_slot();
    test_saturation();

    configure(3, 16'd1000, 16'd20000);
    test_backpressure();

    configure(16, Q15_ONE, 0);
    test_random_traffic(0, 0);
    configure(1, 0, '1);
    test_random_traffic(76, 0);
    configure(CDW'($urandom_range(31, 17)), rand_q15(), rand_q15());
    test_random_traffic(0, 76);
    drain_reports();
    write_reg(REG_SPARE, CDW'($urandom));
    write_reg(shu_pkg::REG_HISTORY_SIZE, {11'($urandom), 5'($urandom_range(15, 2))});
    write_reg(shu_pkg::REG_INIT_F, VW'($urandom));
    write_reg(shu_pkg::REG_INIT_CR, VW'($urandom));
    cfg.valid <= 1'b0;
    test_random_traffic(35, 35);

    drain_reports();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_reports.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
